### hw/rtl/nsr_pkg.sv
// nsr_pkg: widths, constants and stage record for the newton square root block
// no dependencies
package nsr_pkg;

  localparam int unsigned Iterations = 10;
  localparam int unsigned RadW       = 32;
  localparam int unsigned XW         = RadW - 1;
  localparam int unsigned FracW      = 16;
  localparam int unsigned DivW       = XW + FracW + 1;
  localparam int unsigned StageCnt   = Iterations * DivW;
  localparam int unsigned RootW      = 24;
  localparam logic [RootW-1:0] RootMax = {RootW{1'b1}};

  typedef struct packed {
    logic            neg;
    logic [XW-1:0]   x;
    logic [DivW-1:0] est;
    logic [DivW-1:0] rem;
    logic [DivW-1:0] quo;
  } stage_t;

endpackage

### hw/rtl/nsr_in_if.sv
// nsr_in_if: radicand channel, valid/ready plus payload
// depends on nsr_pkg
interface nsr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [nsr_pkg::RadW-1:0]   radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

### hw/rtl/nsr_out_if.sv
// nsr_out_if: root result channel, valid/ready plus payload
// depends on nsr_pkg
interface nsr_out_if;
  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::RootW-1:0]  root;
  logic                       invalid;

  modport source (output valid, output root, output invalid, input ready);
  modport sink   (input valid, input root, input invalid, output ready);
endinterface

### hw/rtl/newton_square_root_top.sv
// newton_square_root_top: pipelined fixed-point newton-raphson square root
// depends on nsr_pkg, nsr_in_if, nsr_out_if
//
//   channel | dir | payload                        | handshake
//   rad_i   | in  | radicand (signed q16.16, 32b)  | valid/ready
//   res_o   | out | root (unsigned q8.16, 24b),    | valid/ready
//           |     | invalid (1b)                   |
//
// one transaction per cycle enters while the pipe is not stalled; each newton
// step is a restoring divider with one quotient bit per stage,
// 48 bits per division
// every stage holds a valid bit; reset clears valid bits only
// the whole pipe advances whenever the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated
module newton_square_root_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsr_in_if.sink    rad_i,
  nsr_out_if.source res_o
);

  localparam int unsigned S = nsr_pkg::StageCnt;
  localparam int unsigned W = nsr_pkg::DivW;

  logic                    en;
  logic [S-1:0]            v_q;
  nsr_pkg::stage_t         stage_q [S];
  nsr_pkg::stage_t         stage_d [S];
  nsr_pkg::stage_t         entry;

  logic                    out_valid_q;
  logic [nsr_pkg::RootW-1:0] root_q, root_d;
  logic                    invalid_q, invalid_d;

  // pipe moves when the output register can take a new value
  assign en          = !out_valid_q || res_o.ready;
  assign rad_i.ready = en;

  // start estimate x/2, at least one lsb
  always_comb begin
    entry.neg = rad_i.radicand[nsr_pkg::RadW-1];
    entry.x   = rad_i.radicand[nsr_pkg::XW-1:0];
    entry.est = W'(entry.x >> 1);
    if (entry.est == '0) begin
      entry.est = W'(1);
    end
    entry.rem = '0;
    entry.quo = '0;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    localparam int unsigned B = W - 1 - (s % W);
    nsr_pkg::stage_t prev;
    logic            prev_v;
    logic [W:0]      shifted;
    logic            ge;
    logic [W:0]      sum;
    logic            nbit;

    if (s == 0) begin : g_first
      assign prev   = entry;
      assign prev_v = rad_i.valid;
    end else begin : g_next
      assign prev   = stage_q[s-1];
      assign prev_v = v_q[s-1];
    end

    // dividend is x shifted up by the fraction width
    if (B >= nsr_pkg::FracW && B < nsr_pkg::FracW + nsr_pkg::XW) begin : g_dbit
      assign nbit = prev.x[B - nsr_pkg::FracW];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    always_comb begin
      stage_d[s] = prev;
      if (B == W - 1) begin
        shifted = {W'(0), nbit};
        stage_d[s].quo = '0;
      end else begin
        shifted = {prev.rem, nbit};
      end
      ge = shifted >= {1'b0, prev.est};
      stage_d[s].rem = ge ? W'(shifted - {1'b0, prev.est}) : W'(shifted);
      stage_d[s].quo = {stage_d[s].quo[W-2:0], ge};
      if (B == W - 1) begin
        stage_d[s].quo = {{(W-1){1'b0}}, ge};
      end
      sum = '0;
      if (B == 0) begin
        // newton update, est = (est + q) / 2, kept at least one lsb
        sum = {1'b0, prev.est} + {1'b0, stage_d[s].quo};
        stage_d[s].est = sum[W:1];
        if (stage_d[s].est == '0) begin
          stage_d[s].est = W'(1);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  // final saturation and special cases
  always_comb begin
    invalid_d = stage_q[S-1].neg;
    if (stage_q[S-1].neg || stage_q[S-1].x == '0) begin
      root_d = '0;
    end else if (stage_q[S-1].est > W'(nsr_pkg::RootMax)) begin
      root_d = nsr_pkg::RootMax;
    end else begin
      root_d = stage_q[S-1].est[nsr_pkg::RootW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[S-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_q    <= root_d;
      invalid_q <= invalid_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.root    = root_q;
  assign res_o.invalid = invalid_q;

`ifndef SYNTHESIS
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.invalid |-> res_o.root == '0)
    else $error("invalid result with nonzero root");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipe moved during stall");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[S-1] |=> out_valid_q)
    else $error("last stage transaction dropped");

  a_est_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S-1] |-> stage_q[S-1].est != '0)
    else $error("estimate fell to zero");
`endif

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for newton_square_root_top
// depends on nsr_pkg, nsr_in_if, nsr_out_if and the block itself
// radicands are driven with random gaps, roots are predicted and checked in order
module tb_top;

  localparam int unsigned Latency    = nsr_pkg::Iterations * nsr_pkg::DivW + 1;
  localparam int unsigned WatchLimit = 4 * Latency + 2000;
  localparam int unsigned RandCount  = 630;

  typedef struct {
    logic [nsr_pkg::RootW-1:0] root;
    logic                      invalid;
  } root_res_t;

  // scoreboard: predicts each root and holds expectations in order
  class root_scoreboard;
    root_res_t pending_roots[$];
    int        mismatches;

    // one line and a count per mismatch
    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function root_res_t predict_root(logic [31:0] rad);
      root_res_t    r;
      logic [63:0]  num;
      logic [63:0]  est;
      logic [63:0]  quo;
      r.root    = '0;
      r.invalid = 1'b0;
      if (rad[31]) begin
        r.invalid = 1'b1;
      end else if (rad != 0) begin
        num = {32'd0, rad} << 16;
        est = {32'd0, rad} >> 1;
        if (est == 0) est = 64'd1;
        for (int k = 0; k < nsr_pkg::Iterations; k++) begin
          quo = num / est;
          est = (est + quo) >> 1;
          if (est == 0) est = 64'd1;
        end
        r.root = (est > {40'd0, nsr_pkg::RootMax}) ? nsr_pkg::RootMax
                                                   : est[nsr_pkg::RootW-1:0];
      end
      return r;
    endfunction

    function void note_radicand(logic [31:0] rad);
      pending_roots.push_back(predict_root(rad));
    endfunction

    task check_root(logic [nsr_pkg::RootW-1:0] root, logic invalid);
      root_res_t want;
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result root=%h invalid=%b", root, invalid));
        return;
      end
      want = pending_roots.pop_front();
      if (root !== want.root)
        report_mismatch($sformatf("root got %h want %h", root, want.root));
      if (invalid !== want.invalid)
        report_mismatch($sformatf("invalid got %b want %b", invalid, want.invalid));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   idle_cycles = 0;
  bit   stim_done;
  bit   long_hold;

  nsr_in_if  rad_if ();
  nsr_out_if res_if ();
  root_scoreboard sb;

  newton_square_root_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rad_i (rad_if.sink),
    .res_o (res_if.source)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // drive one radicand after a random gap, return once the transaction is taken
  task automatic send_radicand(logic [31:0] rad, int gap);
    repeat (gap) @(posedge clk_i);
    rad_if.valid    <= 1'b1;
    rad_if.radicand <= rad;
    do @(posedge clk_i); while (!rad_if.ready);
    sb.note_radicand(rad);
  endtask

  task automatic drop_valid();
    rad_if.valid <= 1'b0;
  endtask

  // radicand mix: mostly positive, with every bit toggled over the run
  function automatic logic [31:0] random_radicand();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $urandom_range(0, 255);
      2:       return 32'h7fff_ffff - $urandom_range(0, 1023);
      3:       return 32'h8000_0000 | $urandom();
      default: return 32'({1'b0, $urandom()} >> $urandom_range(0, 30));
    endcase
  endfunction

  // stimulus process
  initial begin
    logic [31:0] dir_rads[$];
    int          gap;
    sb = new();
    stim_done       = 1'b0;
    rst_ni          = 1'b0;
    rad_if.valid    = 1'b0;
    rad_if.radicand = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: zero, tiny, one, extremes, negatives, all-ones patterns
    dir_rads = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                 32'h0001_0000, 32'h0004_0000, 32'h0000_4000, 32'h7fff_ffff,
                 32'h8000_0000, 32'hffff_ffff, 32'h8000_0001, 32'h5555_5555,
                 32'h2aaa_aaaa, 32'h0000_ffff, 32'h00ff_ffff, 32'h4000_0000,
                 32'h0190_0000, 32'h0000_0004};
    foreach (dir_rads[i]) begin
      gap = (i % 3 == 0) ? int'($urandom_range(0, 4)) : 0;
      if (gap != 0) drop_valid();
      send_radicand(dir_rads[i], gap);
    end
    drop_valid();

    // sender pause until every expected root has come back
    while (sb.pending_roots.size() != 0) @(posedge clk_i);

    for (int n = 0; n < RandCount; n++) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      if (gap != 0) drop_valid();
      send_radicand(random_radicand(), gap);
    end
    drop_valid();
    stim_done = 1'b1;
  end

  // receiver: random ready, with one long hold-off early in the random part
  initial begin
    int stall;
    res_if.ready = 1'b0;
    long_hold    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold && sb.pending_roots.size() > 40) begin
        long_hold = 1'b1;
        res_if.ready <= 1'b0;
        repeat (3 * Latency) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_root(res_if.root, res_if.invalid);
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if (!rst_ni || (rad_if.valid && rad_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // end of run
  initial begin
    fork
      begin
        wait (stim_done);
        while (sb.pending_roots.size() != 0) @(posedge clk_i);
        repeat (Latency + 20) @(posedge clk_i);
        if (sb.mismatches == 0 && sb.pending_roots.size() == 0)
          $display("newton_square_root_top regression: pass");
        else
          $display("newton_square_root_top regression: fail");
      end
      begin
        wait (idle_cycles >= WatchLimit);
        $display("watchdog: no transaction for %0d cycles", WatchLimit);
        $display("newton_square_root_top regression: fail");
      end
    join_any
    $finish;
  end
endmodule
